### design/sstii_pkg.sv
// Shared widths, register codes and types for the subsampled integral image block.
package sstii_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_STEP   = 8;

    localparam int LUMA_W    = 8;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 8;
    localparam int LSUM_W    = 24;
    localparam int GCNT_W    = 17;
    localparam int RLACC_W   = 16;
    localparam int RGACC_W   = 9;
    localparam int WCOL_W    = 11;
    localparam int STEP_W    = 4;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(WCOL_W + 1);
    localparam int STORE_W   = LSUM_W + GCNT_W;

    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_FIELD_W = COL_W + ROW_W + LSUM_W + GCNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 2'd2;

    localparam logic [STEP_W-1:0] RST_STEP   = 4'd1;
    localparam logic [DIM_W-1:0]  RST_WIDTH  = 9'd160;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 9'd120;

    // One kept sample on its way from the scan counters to the line store
    typedef struct packed {
        logic [WCOL_W-1:0]  col;
        logic [ROW_W-1:0]   row;
        logic [RLACC_W-1:0] luma_acc;
        logic [RGACC_W-1:0] green_acc;
        logic               use_prev;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### design/sstii_divider.sv
// Restoring divider that rebuilds the column quotient and phase after a step change.
module sstii_divider #(
    parameter int DIVISOR_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sstii_pkg::WCOL_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output logic [sstii_pkg::WCOL_W-1:0]  quotient,
    output logic [DIVISOR_W-1:0]          remainder,
    output sstii_pkg::div_status_t        status
);
    import sstii_pkg::*;

    logic [WCOL_W-1:0]    quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic                 fits;
    logic [DIVISOR_W:0]   rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WCOL_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(WCOL_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // One quotient bit per cycle, MSB first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WCOL_W-2:0], fits};
            rem_reg <= rem_sub[DIVISOR_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### design/sstii_scan.sv
// Scan counters: word column, line phase, output row and the row accumulators.
module sstii_scan (
    input  logic                                                        clk,
    input  logic                                                        rst_n,
    input  logic                                                        accept,
    input  logic                                                        frame_start,
    input  logic [sstii_pkg::LUMA_W-1:0]                                luma,
    input  logic                                                        is_green,
    input  logic [$clog2(sstii_pkg::MAX_STEP+1)-1:0]                    step_eff,
    input  logic [$clog2(sstii_pkg::MAX_WIDTH+1)-1:0]                   width_eff,
    input  logic [$clog2(sstii_pkg::MAX_HEIGHT+1)-1:0]                  height_eff,
    input  logic [$clog2(sstii_pkg::MAX_WIDTH*sstii_pkg::MAX_STEP+1)-1:0] line_words,
    input  logic                                                        div_done,
    input  logic [sstii_pkg::WCOL_W-1:0]                                div_q,
    input  logic [$clog2(sstii_pkg::MAX_STEP+1)-1:0]                    div_r,
    output logic [sstii_pkg::WCOL_W-1:0]                                word_column,
    output logic                                                        keep,
    output sstii_pkg::sample_t                                          sample
);
    import sstii_pkg::*;

    localparam int RW  = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int LPW = $clog2(2 * MAX_STEP);
    localparam int OW  = $clog2(MAX_HEIGHT + 1);

    logic [WCOL_W-1:0]  wcol_reg,  wcol_next;
    logic [WCOL_W-1:0]  quo_reg,   quo_next;
    logic [RW-1:0]      rem_reg,   rem_next;
    logic [LPW-1:0]     phase_reg, phase_next;
    logic [OW-1:0]      orow_reg,  orow_next;
    logic [RLACC_W-1:0] lacc_reg,  lacc_next;
    logic [RGACC_W-1:0] gacc_reg,  gacc_next;

    logic [WCOL_W-1:0]  wcol;
    logic [WCOL_W-1:0]  quo;
    logic [RW-1:0]      rem;
    logic [LPW-1:0]     phase;
    logic [OW-1:0]      orow;
    logic [RLACC_W-1:0] lacc;
    logic [RGACC_W-1:0] gacc;
    logic [RLACC_W-1:0] lacc_upd;
    logic [RGACC_W-1:0] gacc_upd;
    logic [WCOL_W-1:0]  wcol_inc;
    logic               kept_line;
    logic               line_end;

    // A frame start clears the counters before its own word is handled
    always_comb
    begin
        wcol  = frame_start ? '0 : wcol_reg;
        quo   = frame_start ? '0 : quo_reg;
        rem   = frame_start ? '0 : rem_reg;
        phase = frame_start ? '0 : phase_reg;
        orow  = frame_start ? '0 : orow_reg;
        lacc  = frame_start ? '0 : lacc_reg;
        gacc  = frame_start ? '0 : gacc_reg;

        kept_line = (phase == '0) && (32'(orow) < 32'(height_eff));
        keep      = kept_line && (32'(wcol) < 32'(line_words)) && (rem == '0);
        lacc_upd  = (keep && !is_green) ? (lacc + RLACC_W'(luma)) : lacc;
        gacc_upd  = (keep && is_green) ? (gacc + RGACC_W'(1)) : gacc;
        wcol_inc  = wcol + WCOL_W'(1);
        line_end  = 32'(wcol_inc) >= 32'(line_words);

        sample.col       = quo;
        sample.row       = ROW_W'(orow);
        sample.luma_acc  = lacc_upd;
        sample.green_acc = gacc_upd;
        sample.use_prev  = orow != '0;
        sample.last      = (32'(quo) == 32'(width_eff) - 1)
                        && (32'(orow) == 32'(height_eff) - 1);
    end

    always_comb
    begin
        wcol_next  = wcol_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        orow_next  = orow_reg;
        lacc_next  = lacc_reg;
        gacc_next  = gacc_reg;
        if (div_done)
        begin
            quo_next = div_q;
            rem_next = RW'(div_r);
        end
        else if (accept)
        begin
            wcol_next  = wcol_inc;
            quo_next   = quo;
            rem_next   = rem;
            phase_next = phase;
            orow_next  = orow;
            lacc_next  = lacc_upd;
            gacc_next  = gacc_upd;
            if (line_end)
            begin
                wcol_next = '0;
                quo_next  = '0;
                rem_next  = '0;
                lacc_next = '0;
                gacc_next = '0;
                orow_next = orow + OW'(kept_line);
                if (32'(phase) + 1 >= 2 * 32'(step_eff))
                    phase_next = '0;
                else
                    phase_next = phase + LPW'(1);
            end
            else if (wcol_inc == '0)
            begin
                // 11-bit column wrap without a line end
                quo_next = '0;
                rem_next = '0;
            end
            else if (32'(rem) + 1 == 32'(step_eff))
            begin
                quo_next = quo + WCOL_W'(1);
                rem_next = '0;
            end
            else
            begin
                rem_next = rem + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcol_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            phase_reg <= '0;
            orow_reg  <= '0;
            lacc_reg  <= '0;
            gacc_reg  <= '0;
        end
        else
        begin
            wcol_reg  <= wcol_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            phase_reg <= phase_next;
            orow_reg  <= orow_next;
            lacc_reg  <= lacc_next;
            gacc_reg  <= gacc_next;
        end
    end

    assign word_column = wcol_reg;

endmodule

### design/sstii_accum.sv
// Line store read-modify-write stage and result register.
module sstii_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          keep,
    input  sstii_pkg::sample_t            sample,
    input  logic                          out_ready,
    output logic                          room,
    output logic                          out_valid,
    output logic [sstii_pkg::COL_W-1:0]   column,
    output logic [sstii_pkg::ROW_W-1:0]   row,
    output logic [sstii_pkg::LSUM_W-1:0]  luma_sum,
    output logic [sstii_pkg::GCNT_W-1:0]  green_count,
    output logic                          frame_done
);
    import sstii_pkg::*;

    localparam int IW = $clog2(MAX_WIDTH);

    logic [STORE_W-1:0] store_mem [MAX_WIDTH];
    logic [STORE_W-1:0] prev_reg;
    sample_t            s1_reg;
    logic               s1_valid_reg;
    logic               out_valid_reg;
    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [LSUM_W-1:0]  luma_sum_reg;
    logic [GCNT_W-1:0]  green_count_reg;
    logic               frame_done_reg;

    logic               load;
    logic               advance;
    logic [LSUM_W-1:0]  prev_l;
    logic [GCNT_W-1:0]  prev_g;
    logic [LSUM_W-1:0]  sum_l;
    logic [GCNT_W-1:0]  sum_g;

    always_comb
    begin
        advance = !out_valid_reg || out_ready;
        room    = !s1_valid_reg || advance;
        load    = accept && keep;
        // Row zero has nothing above it
        prev_l  = s1_reg.use_prev ? prev_reg[STORE_W-1:GCNT_W] : '0;
        prev_g  = s1_reg.use_prev ? prev_reg[GCNT_W-1:0] : '0;
        sum_l   = LSUM_W'(s1_reg.luma_acc) + prev_l;
        sum_g   = GCNT_W'(s1_reg.green_acc) + prev_g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_reg <= sample;
        if (advance && s1_valid_reg)
        begin
            column_reg      <= COL_W'(s1_reg.col);
            row_reg         <= s1_reg.row;
            luma_sum_reg    <= sum_l;
            green_count_reg <= sum_g;
            frame_done_reg  <= s1_reg.last;
        end
    end

    // Read on entry to the stage, write back as the sample leaves it
    always_ff @(posedge clk)
    begin
        if (load)
            prev_reg <= store_mem[sample.col[IW-1:0]];
        if (advance && s1_valid_reg)
            store_mem[s1_reg.col[IW-1:0]] <= {sum_l, sum_g};
    end

    assign out_valid   = out_valid_reg;
    assign column      = column_reg;
    assign row         = row_reg;
    assign luma_sum    = luma_sum_reg;
    assign green_count = green_count_reg;
    assign frame_done  = frame_done_reg;

endmodule

### design/subsampled_two_channel_integral_image.sv
// A kept pixel word passes the stage and result registers. Throughput: one pixel
// word per cycle unless back-pressure or a register write holds off input; line
// store read and write-back bracket one stage. A sample_step write holds off input
// for the 11-step quotient rebuild plus load; any other register write holds off
// input while the line length settles. Reset: counters, accumulators and registers
// to defaults (1, 160, 120); the line store is not cleared, row zero ignores reads.
module subsampled_two_channel_integral_image (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sstii_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // luma
    input  logic [sstii_pkg::IN_USER_W-1:0]   s_axis_tuser,  // frame_start, is_green
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sstii_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // column, row, luma_sum,
                                                             // green_count, zero pad
    output logic                              m_axis_tlast,  // frame_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sstii_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sstii_pkg::DIM_W-1:0]       cfg_data
);
    import sstii_pkg::*;

    localparam int SW  = $clog2(MAX_STEP + 1);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int LWW = $clog2(MAX_WIDTH * MAX_STEP + 1);

    logic [STEP_W-1:0] step_cfg_reg;
    logic [DIM_W-1:0]  width_cfg_reg;
    logic [DIM_W-1:0]  height_cfg_reg;
    logic [LWW-1:0]    line_words_reg;
    logic              settle_reg;

    logic [SW-1:0]     step_eff;
    logic [WW-1:0]     width_eff;
    logic [HW-1:0]     height_eff;
    logic [SW-1:0]     new_step;
    logic              cfg_fire;
    logic              div_start;
    logic              accept;
    logic              room;
    logic              keep;
    sample_t           sample;
    div_status_t       div_stat;
    logic [WCOL_W-1:0] div_q;
    logic [SW-1:0]     div_r;
    logic [WCOL_W-1:0] word_column;

    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [LSUM_W-1:0] luma_sum;
    logic [GCNT_W-1:0] green_count;

    // Clamp the registers and the new step value into their legal ranges
    always_comb
    begin
        if (step_cfg_reg == '0)
            step_eff = SW'(1);
        else if (32'(step_cfg_reg) > MAX_STEP)
            step_eff = SW'(MAX_STEP);
        else
            step_eff = SW'(step_cfg_reg);

        if (cfg_data[STEP_W-1:0] == '0)
            new_step = SW'(1);
        else if (32'(cfg_data[STEP_W-1:0]) > MAX_STEP)
            new_step = SW'(MAX_STEP);
        else
            new_step = SW'(cfg_data[STEP_W-1:0]);

        if (width_cfg_reg == '0)
            width_eff = WW'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            height_eff = HW'(1);
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(height_cfg_reg);
    end

    assign cfg_ready     = !div_stat.busy && !div_stat.done;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign div_start     = cfg_fire && (cfg_index == CFG_SAMPLE_STEP);
    assign s_axis_tready = !settle_reg && !div_stat.busy && !div_stat.done && room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg   <= RST_STEP;
            width_cfg_reg  <= RST_WIDTH;
            height_cfg_reg <= RST_HEIGHT;
            settle_reg     <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_fire;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_STEP: step_cfg_reg   <= cfg_data[STEP_W-1:0];
                    CFG_OUT_WIDTH:   width_cfg_reg  <= cfg_data;
                    CFG_OUT_HEIGHT:  height_cfg_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // Line length kept in a register; input holds off while it settles
    always_ff @(posedge clk)
    begin
        line_words_reg <= LWW'(32'(width_eff) * 32'(step_eff));
    end

    sstii_divider #(
        .DIVISOR_W (SW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (word_column),
        .divisor   (new_step),
        .quotient  (div_q),
        .remainder (div_r),
        .status    (div_stat)
    );

    sstii_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (s_axis_tuser[0]),
        .luma        (s_axis_tdata[LUMA_W-1:0]),
        .is_green    (s_axis_tuser[1]),
        .step_eff    (step_eff),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .line_words  (line_words_reg),
        .div_done    (div_stat.done),
        .div_q       (div_q),
        .div_r       (div_r),
        .word_column (word_column),
        .keep        (keep),
        .sample      (sample)
    );

    sstii_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .keep        (keep),
        .sample      (sample),
        .out_ready   (m_axis_tready),
        .room        (room),
        .out_valid   (m_axis_tvalid),
        .column      (column),
        .row         (row),
        .luma_sum    (luma_sum),
        .green_count (green_count),
        .frame_done  (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, green_count, luma_sum, row, column};

endmodule
